// ----- sv/lru_key_value_cache_top_defines.svh -----
// Assertion macros shared by the LRU cache checker.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LKVC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lkvc_pkg.sv -----
// Shared constants and controller/datapath interface types for the LRU cache.
package lkvc_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 31;

    localparam int              CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic accept;    // latch the incoming request
        logic look;      // compare, update ranks, access value RAM
        logic load_out;  // move lookup result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic is_get;    // latched request is a get
        logic out_free;  // output register can take a result this cycle
    } t_dp_status;

endpackage

// ----- sv/lkvc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/lkvc_datapath.sv -----
// Key store, recency ranks, occupancy, capacity register, value RAM and output register.
module lkvc_datapath #(
    parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lkvc_pkg::t_dp_cmd             i_cmd,
    output lkvc_pkg::t_dp_status          o_status,
    input  logic                          i_req_type,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [VALUE_BITS-1:0]         i_value,
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::CAP_BITS-1:0] i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_hit,
    output logic [VALUE_BITS-1:0]         o_value_out
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lkvc_pkg::CAP_BITS) ? OCC_W : lkvc_pkg::CAP_BITS;

    logic                          r_req_type;
    logic [KEY_BITS-1:0]           r_key;
    logic [VALUE_BITS-1:0]         r_value;
    logic [lkvc_pkg::CAP_BITS-1:0] r_cap;
    logic [OCC_W-1:0]              r_occ;
    logic [KEY_BITS-1:0]           r_keys  [ENTRIES];
    logic [IDX_W-1:0]              r_ranks [ENTRIES];
    logic                          r_hit;
    logic                          r_o_valid;
    logic                          r_o_hit;
    logic [VALUE_BITS-1:0]         r_o_value;

    logic [ENTRIES-1:0] valid;
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] victim;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   hit_rank;
    logic [IDX_W-1:0]   victim_idx;
    logic [OCC_W-1:0]   occ_m1;
    logic [IDX_W-1:0]   last_rank;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               full;
    logic [IDX_W-1:0]   slot;
    logic               is_put;
    logic [IDX_W-1:0]   ram_addr;
    logic               ram_we;
    logic               ram_re;
    logic [VALUE_BITS-1:0] ram_rdata;

    assign is_put    = (r_req_type == lkvc_pkg::REQ_PUT);
    assign occ_m1    = r_occ - OCC_W'(1);
    assign last_rank = occ_m1[IDX_W-1:0];

    // Valid entries always fill slots 0 .. occupancy-1: a slot is only
    // vacated by an eviction that refills it in the same step.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            valid[i]  = (OCC_W'(i) < r_occ);
            match[i]  = valid[i] && (r_keys[i] == r_key);
            victim[i] = valid[i] && (r_ranks[i] == last_rank);
        end
    end

    assign hit = |match;

    // Keys are unique among valid entries, so match and victim are one-hot.
    always_comb begin
        hit_idx    = '0;
        hit_rank   = '0;
        victim_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | r_ranks[i];
            end
            if (victim[i]) begin
                victim_idx = victim_idx | IDX_W'(i);
            end
        end
    end

    // Capacity of zero behaves as one, anything above the store size as full size.
    assign cap_ext = CMP_W'(r_cap);
    always_comb begin
        priority if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign full     = (CMP_W'(r_occ) >= eff_cap);
    assign slot     = full ? victim_idx : r_occ[IDX_W-1:0];
    assign ram_addr = hit ? hit_idx : slot;
    assign ram_we   = i_cmd.look && is_put;
    assign ram_re   = i_cmd.look && !is_put && hit;

    lkvc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (r_value),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= lkvc_pkg::CAP_RESET;
            r_occ     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.look && is_put && !hit && !full) begin
                r_occ <= r_occ + OCC_W'(1);
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_req_type;
            r_key      <= i_key;
            r_value    <= i_value;
        end
        if (i_cmd.look) begin
            r_hit <= hit;
            if (hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (match[i]) begin
                        r_ranks[i] <= '0;
                    end else if (valid[i] && (r_ranks[i] < hit_rank)) begin
                        r_ranks[i] <= r_ranks[i] + IDX_W'(1);
                    end
                end
            end else if (is_put) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (IDX_W'(i) == slot) begin
                        r_ranks[i] <= '0;
                        r_keys[i]  <= r_key;
                    end else if (valid[i]) begin
                        r_ranks[i] <= r_ranks[i] + IDX_W'(1);
                    end
                end
            end
        end
        if (i_cmd.load_out) begin
            r_o_hit   <= r_hit;
            r_o_value <= r_hit ? ram_rdata : '0;
        end
    end

    assign o_status.is_get   = !is_put;
    assign o_status.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid = r_o_valid;
    assign o_hit       = r_o_hit;
    assign o_value_out = r_o_value;

endmodule

// ----- sv/lkvc_ctrl.sv -----
// Request sequencer: accept, lookup/update, result load.
module lkvc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    output lkvc_pkg::t_dp_cmd    o_cmd,
    input  lkvc_pkg::t_dp_status i_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_ready        = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.look     = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_status.is_get ? S_RESP : S_IDLE;
            end
            S_RESP: begin
                // Next transaction overlaps the result load once the output is free.
                o_ready = i_status.out_free;
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_valid) begin
                        o_cmd.accept = 1'b1;
                        n_state      = S_LOOK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/lru_key_value_cache_top.sv -----
// Top level of the fully associative LRU key/value cache.
// Fully associative LRU key/value cache. A get (req_type 0) returns one result:
// hit and the stored value, or hit 0 with value 0 on a miss; a put (req_type 1)
// updates a present key or inserts a new one, evicting the least recent entry
// once occupancy reaches the capacity register (0 acts as 1, values above
// ENTRIES act as ENTRIES), and returns no result. Each request is latched, then
// the lookup state does the parallel key compare and rank update, taking no new
// request; a get loads its result from the value RAM's registered read while the
// next request is accepted, once the output is free. The user must write the
// configuration (i_cfg_we/i_cfg_data) only while idle; the block does not check.
module lru_key_value_cache_top #(
    parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [VALUE_BITS-1:0]         i_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic [VALUE_BITS-1:0]         o_value_out,
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::CAP_BITS-1:0] i_cfg_data
);

    lkvc_pkg::t_dp_cmd    cmd;
    lkvc_pkg::t_dp_status status;

    lkvc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_cmd    (cmd),
        .i_status (status)
    );

    lkvc_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_hit       (o_hit),
        .o_value_out (o_value_out)
    );

endmodule

// ----- sv/lkvc_checker.sv -----
// Port-level checker for the LRU cache, bound to the top level.
`include "lru_key_value_cache_top_defines.svh"

module lkvc_checker #(
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic                  o_hit,
    input logic [VALUE_BITS-1:0] o_value_out
);

    `LKVC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_hit) && $stable(o_value_out), "result changed while stalled")
    `LKVC_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, o_valid && !o_hit, o_value_out == '0, "miss result carries a nonzero value")
    `LKVC_ASSERT_NEXT(a_lookup_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "request accepted during lookup cycle")

endmodule

bind lru_key_value_cache_top lkvc_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_hit       (o_hit),
    .o_value_out (o_value_out)
);

// ----- tb/tb_lru_key_value_cache_top.sv -----
// Self-checking testbench for the fully associative LRU key/value cache.
`timescale 1ns / 1ps

module tb_lru_key_value_cache_top;

    localparam int NUM_ENTRIES = lkvc_pkg::ENTRIES_DEF;
    localparam int KW          = lkvc_pkg::KEY_BITS_DEF;
    localparam int VW          = lkvc_pkg::VALUE_BITS_DEF;
    localparam int CW          = lkvc_pkg::CAP_BITS;

    typedef struct packed {
        logic          hit;
        logic [VW-1:0] value;
    } t_lookup;

    // Mirror of the cache contents plus the queue of lookup results still owed.
    class t_lru_mirror;
        logic [KW-1:0] keys  [NUM_ENTRIES];
        logic [VW-1:0] vals  [NUM_ENTRIES];
        bit            used  [NUM_ENTRIES];
        int unsigned   rank  [NUM_ENTRIES];
        int unsigned   fill;
        logic [CW-1:0] capacity;
        t_lookup       owed_lookups[$];
        int unsigned   errors, gets, hits, puts, evictions;

        function new();
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                keys[i] = '0;
                vals[i] = '0;
                used[i] = 1'b0;
                rank[i] = 0;
            end
            fill      = 0;
            capacity  = lkvc_pkg::CAP_RESET;
            errors    = 0;
            gets      = 0;
            hits      = 0;
            puts      = 0;
            evictions = 0;
        endfunction

        function void set_capacity(logic [CW-1:0] cap);
            capacity = cap;
        endfunction

        function int unsigned eff_capacity();
            if (capacity == 0) return 1;
            if (capacity > NUM_ENTRIES) return NUM_ENTRIES;
            return 32'(capacity);
        endfunction

        // Promote an entry to most recent; newer entries age by one.
        function void touch(int idx);
            int unsigned r;
            r = rank[idx];
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (used[i] && rank[i] < r) rank[i]++;
            rank[idx] = 0;
        endfunction

        function void note_request(logic rt, logic [KW-1:0] k, logic [VW-1:0] v);
            int      idx;
            int      slot;
            int unsigned oldest;
            t_lookup res;
            idx  = -1;
            slot = -1;
            oldest = 0;
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (idx < 0 && used[i] && keys[i] == k) idx = i;

            if (rt == lkvc_pkg::REQ_GET) begin
                gets++;
                if (idx < 0) begin
                    res = '{hit: 1'b0, value: '0};
                end else begin
                    touch(idx);
                    res = '{hit: 1'b1, value: vals[idx]};
                    hits++;
                end
                owed_lookups.push_back(res);
                return;
            end

            puts++;
            if (idx >= 0) begin
                vals[idx] = v;
                touch(idx);
                return;
            end
            if (fill >= eff_capacity()) begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (used[i] && (slot < 0 || rank[i] > oldest)) begin
                        slot   = i;
                        oldest = rank[i];
                    end
                if (slot >= 0) begin
                    used[slot] = 1'b0;
                    fill--;
                    evictions++;
                end
            end
            if (slot < 0) begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (slot < 0 && !used[i]) slot = i;
            end
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (used[i]) rank[i]++;
            keys[slot] = k;
            vals[slot] = v;
            rank[slot] = 0;
            used[slot] = 1'b1;
            fill++;
        endfunction

        function void check_lookup(logic hit, logic [VW-1:0] value_out);
            t_lookup exp;
            if (owed_lookups.size() == 0) begin
                $error("unexpected result: hit=%0d value_out=0x%08h", hit, value_out);
                errors++;
                return;
            end
            exp = owed_lookups.pop_front();
            if (hit !== exp.hit) begin
                $error("hit mismatch: expected %0d, actual %0d", exp.hit, hit);
                errors++;
            end
            if (value_out !== exp.value) begin
                $error("value_out mismatch: expected 0x%08h, actual 0x%08h",
                       exp.value, value_out);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_valid     = 1'b0;
    logic          o_ready;
    logic          i_req_type  = lkvc_pkg::REQ_GET;
    logic [KW-1:0] i_key       = '0;
    logic [VW-1:0] i_value     = '0;
    logic          o_valid;
    logic          i_ready     = 1'b0;
    logic          o_hit;
    logic [VW-1:0] o_value_out;
    logic          i_cfg_we    = 1'b0;
    logic [CW-1:0] i_cfg_data  = '0;

    t_lru_mirror mirror = new();
    bit          sender_burst = 1'b0;
    int unsigned cap_settings = 0;

    lru_key_value_cache_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hit       (o_hit),
        .o_value_out (o_value_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result sink: ready runs broken by stalls, occasionally a long clean run.
    initial begin
        int run;
        int stall;
        @(posedge i_clk);
        forever begin
            i_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 30);
            repeat (run) @(posedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            mirror.check_lookup(o_hit, o_value_out);
    end

    // Called at a rising edge; returns at a rising edge with valid possibly still high.
    task automatic send_request(logic rt, logic [KW-1:0] k, logic [VW-1:0] v);
        int gap;
        i_valid    <= 1'b1;
        i_req_type <= rt;
        i_key      <= k;
        i_value    <= v;
        do @(posedge i_clk); while (!o_ready);
        mirror.note_request(rt, k, v);
        gap = sender_burst ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every owed lookup has come back.
    task automatic drain_lookups();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (mirror.owed_lookups.size() != 0);
    endtask

    task automatic write_capacity(logic [CW-1:0] cap);
        drain_lookups();
        // a trailing put may still be in the pipe
        repeat (12) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror.set_capacity(cap);
        cap_settings++;
    endtask

    task automatic directed_items();
        send_request(lkvc_pkg::REQ_GET, 16'h0000, 31'h0);          // miss on empty store
        send_request(lkvc_pkg::REQ_PUT, 16'h0000, 31'h0);
        send_request(lkvc_pkg::REQ_PUT, 16'hFFFF, 31'h7FFF_FFFF);
        send_request(lkvc_pkg::REQ_GET, 16'h0000, 31'h7FFF_FFFF);
        send_request(lkvc_pkg::REQ_GET, 16'hFFFF, 31'h0);
        send_request(lkvc_pkg::REQ_PUT, 16'h0000, 31'h2AAA_5555);  // update in place
        send_request(lkvc_pkg::REQ_GET, 16'h0000, 31'h0);
        for (int i = 0; i < 14; i++)
            send_request(lkvc_pkg::REQ_PUT, 16'h0100 + i[15:0], 31'h5555_0000 + i[30:0]);
        send_request(lkvc_pkg::REQ_PUT, 16'h0200, 31'h1234_5678);  // full: evicts oldest
        send_request(lkvc_pkg::REQ_GET, 16'hFFFF, 31'h0);
        // shrink below occupancy: a new key swaps out one entry only
        write_capacity(5'd2);
        send_request(lkvc_pkg::REQ_PUT, 16'h0300, 31'h0F0F_0F0F);
        send_request(lkvc_pkg::REQ_GET, 16'h0300, 31'h0);
        send_request(lkvc_pkg::REQ_GET, 16'h0000, 31'h0);
        send_request(lkvc_pkg::REQ_GET, 16'h0105, 31'h0);
    endtask

    task automatic random_phase(logic [CW-1:0] cap, int count);
        logic [KW-1:0] pool[24];
        int            pool_n;
        int            r;
        logic          rt;
        logic [KW-1:0] k;
        logic [VW-1:0] v;
        write_capacity(cap);
        sender_burst = ($urandom_range(0, 3) == 0);
        pool_n = int'(mirror.eff_capacity()) + int'($urandom_range(1, 4));
        for (int i = 0; i < 24; i++)
            pool[i] = KW'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 1) == 1) begin
            pool[0] = 16'h0000;
            pool[1] = 16'hFFFF;
        end
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain_lookups();
            rt = ($urandom_range(0, 99) < 50) ? lkvc_pkg::REQ_GET : lkvc_pkg::REQ_PUT;
            k  = ($urandom_range(0, 99) < 88) ? pool[$urandom_range(0, pool_n - 1)]
                                              : KW'($urandom);
            r  = $urandom_range(0, 19);
            v  = (r == 0) ? '0 : (r == 1) ? '1 : VW'($urandom);
            send_request(rt, k, v);
        end
    endtask

    initial begin
        logic [CW-1:0] caps[10];
        int waited;
        caps = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd2, 5'd17, 5'd7, 5'd3, 5'd12, 5'd16};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();
        foreach (caps[p])
            random_phase(caps[p], 190);

        i_valid <= 1'b0;
        waited = 0;
        while (mirror.owed_lookups.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (mirror.owed_lookups.size() != 0) begin
            $error("%0d lookup results never arrived", mirror.owed_lookups.size());
            mirror.errors++;
        end

        $display("Run covered %0d gets (%0d hits) and %0d puts with %0d evictions,",
                 mirror.gets, mirror.hits, mirror.puts, mirror.evictions);
        $display("across %0d capacity writes including 0, 1, 16, 17 and 31.", cap_settings);
        if (mirror.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/lkvc_pkg.sv
sv/lkvc_ram.sv
sv/lkvc_datapath.sv
sv/lkvc_ctrl.sv
sv/lru_key_value_cache_top.sv
sv/lkvc_checker.sv
tb/tb_lru_key_value_cache_top.sv
